>>> src/kreyv_pkg.sv
// ----------------------------------------------------------------------------
// Kreyvium package
// Sizes, register indexes, action codes and sequencer states shared by the
// Kreyvium keystream block.
// ----------------------------------------------------------------------------
package kreyv_pkg;

    localparam int STATE_BITS   = 288;
    localparam int RING_BITS    = 128;
    localparam int KEY_IN_STATE = 93;
    localparam int IV_END       = KEY_IN_STATE + RING_BITS;   // first all-ones bit
    localparam int WARMUP       = 4 * STATE_BITS;             // 1152 rounds
    localparam int CNT_W        = $clog2(WARMUP + 1);

    localparam int REG_W        = 64;
    localparam int CFG_IDX_W    = 2;

    localparam logic [REG_W-1:0] IV_RESET = 64'h8888_8888_8888_8888;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    localparam logic [3:0] MAX_BITS = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WARM = 3'b010,
        ST_DATA = 3'b100
    } t_fsm;

endpackage

>>> src/kreyvium_keystream_cipher.sv
// ----------------------------------------------------------------------------
// Kreyvium keystream cipher
// A load request runs 1152 warm-up rounds, one per cycle, and returns nothing;
// a data request runs bit_count (saturated to 8) rounds, one per cycle, then
// gives its byte once the output is free. A new request is taken only in idle,
// after the last one is done, so a stalled output holds back the next request.
// Reset (synchronous, active low) clears the state and rings to zero, sets the
// key registers to zero and the IV registers to bytes of 0x88.
// ----------------------------------------------------------------------------
module kreyvium_keystream_cipher
    import kreyv_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    // Request stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [7:0] data_in, [11:8] bit_count, rest zero
    input  logic                 s_axis_tuser,  // [0] action
    // Result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata   // [7:0] data_out
);

    logic [REG_W-1:0]      r_key_low, r_key_high, r_iv_low, r_iv_high;
    logic [STATE_BITS-1:0] r_state, n_state;
    logic [RING_BITS-1:0]  r_key_ring, n_key_ring;
    logic [RING_BITS-1:0]  r_iv_ring, n_iv_ring;
    t_fsm                  r_fsm, n_fsm;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [2:0]            r_pos, n_pos;
    logic [7:0]            r_data, n_data;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_data, n_out_data;

    logic [RING_BITS-1:0]  key_full, iv_full;
    logic [STATE_BITS-1:0] load_state, round_state;
    logic [RING_BITS-1:0]  key_rev, iv_rev;
    logic                  kb, ib, ta, tb, tc, z, fa, fb, fc;
    logic                  in_fire, out_free;
    logic [3:0]            sat_count;

    assign key_full = {r_key_high, r_key_low};
    assign iv_full  = {r_iv_high, r_iv_low};

    // Load image: key, then IV, then ones with a zero in the top bit.
    always_comb begin
        load_state = '0;
        load_state[KEY_IN_STATE-1:0]      = key_full[KEY_IN_STATE-1:0];
        load_state[IV_END-1:KEY_IN_STATE] = iv_full;
        load_state[STATE_BITS-2:IV_END]   = '1;
        load_state[STATE_BITS-1]          = 1'b0;
        for (int i = 0; i < RING_BITS; i++) begin
            key_rev[i] = key_full[RING_BITS-1-i];
            iv_rev[i]  = iv_full[RING_BITS-1-i];
        end
    end

    // The one round unit, reused in every round of warm-up and data.
    always_comb begin
        kb = r_key_ring[RING_BITS-1];
        ib = r_iv_ring[RING_BITS-1];
        ta = r_state[65] ^ r_state[92];
        tb = r_state[161] ^ r_state[176];
        tc = r_state[242] ^ r_state[287] ^ kb;
        z  = ta ^ tb ^ tc;
        fa = ta ^ (r_state[90] & r_state[91]) ^ r_state[170] ^ ib;
        fb = tb ^ (r_state[174] & r_state[175]) ^ r_state[263];
        fc = tc ^ (r_state[285] & r_state[286]) ^ r_state[68];
        round_state      = {r_state[STATE_BITS-2:0], fc};
        round_state[93]  = fa;
        round_state[177] = fb;
    end

    assign s_axis_tready = (r_fsm == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign sat_count     = (s_axis_tdata[11:8] > MAX_BITS) ? MAX_BITS : s_axis_tdata[11:8];

    always_comb begin
        n_fsm       = r_fsm;
        n_state     = r_state;
        n_key_ring  = r_key_ring;
        n_iv_ring   = r_iv_ring;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_data      = r_data;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        case (r_fsm)
            ST_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser == ACT_LOAD) begin
                        n_state    = load_state;
                        n_key_ring = key_rev;
                        n_iv_ring  = iv_rev;
                        n_cnt      = CNT_W'(WARMUP);
                        n_fsm      = ST_WARM;
                    end else begin
                        n_cnt  = CNT_W'(sat_count);
                        n_pos  = 3'd7;
                        n_data = s_axis_tdata[7:0];
                        n_fsm  = ST_DATA;
                    end
                end
            end
            ST_WARM: begin
                n_state    = round_state;
                n_key_ring = {r_key_ring[RING_BITS-2:0], kb};
                n_iv_ring  = {r_iv_ring[RING_BITS-2:0], ib};
                n_cnt      = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_fsm = ST_IDLE;
                end
            end
            ST_DATA: begin
                if (r_cnt != '0) begin
                    n_state       = round_state;
                    n_key_ring    = {r_key_ring[RING_BITS-2:0], kb};
                    n_iv_ring     = {r_iv_ring[RING_BITS-2:0], ib};
                    n_cnt         = r_cnt - CNT_W'(1);
                    n_data[r_pos] = r_data[r_pos] ^ z;
                    n_pos         = r_pos - 3'd1;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_data;
                    n_fsm       = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_key_ring  <= '0;
            r_iv_ring   <= '0;
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_iv_low    <= IV_RESET;
            r_iv_high   <= IV_RESET;
        end else begin
            r_fsm       <= n_fsm;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            r_key_ring  <= n_key_ring;
            r_iv_ring   <= n_iv_ring;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    REG_KEY_HIGH: r_key_high <= i_cfg_data;
                    REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    REG_IV_HIGH:  r_iv_high  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_data     <= n_data;
        r_out_data <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A load request starts a full warm-up.
    a_load_starts_warm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && s_axis_tuser == ACT_LOAD) |=> (r_fsm == ST_WARM && r_cnt == CNT_W'(WARMUP)))
        else $error("load request did not start warm-up");

    // A data request never has more than eight rounds pending.
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_DATA) |-> (r_cnt <= CNT_W'(MAX_BITS)))
        else $error("data round count out of range");

    // A result appears only when a data request finishes.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_fsm) == ST_DATA && $past(r_cnt) == '0))
        else $error("result without finished data request");

    // Warm-up never returns to idle with rounds left.
    a_warm_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_WARM && r_cnt != CNT_W'(1)) |=> (r_fsm == ST_WARM))
        else $error("warm-up ended early");

endmodule
